@@ src/icosphere_vertex_generator_assert.svh @@
// Assertion macros shared by the icosphere vertex generator RTL.
`ifndef ICOSPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define ICOSPHERE_VERTEX_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICOVG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ICOVG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/icovg_pkg.sv @@
// Types, constants and corner tables for the icosphere vertex generator.
package icovg_pkg;

  localparam int unsigned MaxDetail = 64;
  localparam int unsigned NumStrips = 5;

  typedef logic signed [13:0] coord_t;
  // Element 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][13:0] cvec_t;

  localparam coord_t OneQ = 14'sd4096;
  localparam coord_t PhiQ = 14'sd6627;

  typedef enum logic [3:0] {
    CN0 = 4'd0, CN1 = 4'd1, CN2 = 4'd2, CN3 = 4'd3, CN4 = 4'd4,
    CS0 = 4'd5, CS1 = 4'd6, CS2 = 4'd7, CS3 = 4'd8, CS4 = 4'd9,
    CNP = 4'd10, CSP = 4'd11
  } corner_e;

  typedef struct packed {
    logic            oor;
    logic [15:0]     index;
    logic [2:0][23:0] w;
  } side_t;

  typedef struct packed {
    logic             oor;
    logic [15:0]      index;
    logic             lzero;
    logic [32:0]      dv;
    logic [2:0]       neg;
    logic [2:0][49:0] rem;
    logic [2:0][16:0] q;
  } dstage_t;

  function automatic cvec_t mk_f(coord_t x, coord_t y, coord_t z);
    mk_f = {z, y, x};
  endfunction

  function automatic cvec_t corner_f(corner_e id);
    cvec_t v;
    unique case (id)
      CN0:     v = mk_f(14'sd0, -OneQ, PhiQ);
      CN1:     v = mk_f(PhiQ, 14'sd0, OneQ);
      CN2:     v = mk_f(OneQ, PhiQ, 14'sd0);
      CN3:     v = mk_f(-OneQ, PhiQ, 14'sd0);
      CN4:     v = mk_f(-PhiQ, 14'sd0, OneQ);
      CS0:     v = mk_f(-OneQ, -PhiQ, 14'sd0);
      CS1:     v = mk_f(OneQ, -PhiQ, 14'sd0);
      CS2:     v = mk_f(PhiQ, 14'sd0, -OneQ);
      CS3:     v = mk_f(14'sd0, OneQ, -PhiQ);
      CS4:     v = mk_f(-PhiQ, 14'sd0, -OneQ);
      CNP:     v = mk_f(14'sd0, OneQ, PhiQ);
      CSP:     v = mk_f(14'sd0, -OneQ, -PhiQ);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] mod5_f(logic [2:0] v);
    logic [2:0] r;
    unique case (v)
      3'd5:    r = 3'd0;
      3'd6:    r = 3'd1;
      3'd7:    r = 3'd2;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

@@ src/icosphere_vertex_generator.sv @@
// Pipelined icosphere vertex generator: grid point in, buffer index and unit vertex out.
//
//  channel   | dir | fields (tdata from bit 0 up)               | tuser
//  s_axis    | in  | strip[2:0] column[9:3] row[17:10] pad       | -
//  m_axis    | out | vertex_index pos_x pos_y pos_z (16 b each)  | out_of_range
//  cfg       | in  | detail[6:0], written when cfg_we_i is high  | -
//
// One word is taken per clock unless a stalled output has backed the pipeline up to the first stage.
// The 32-step square-root pipeline and the 17-step divider make up most of the stages.
// Reset clears all stage valid bits and sets detail to 1.
// A stage advances whenever it or any later stage holds a bubble, so an
// output stall only backs up as far as the pipeline is full.
`include "icosphere_vertex_generator_assert.svh"

module icosphere_vertex_generator
  import icovg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // strip, column, row, zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // vertex_index, pos_x, pos_y, pos_z
  output logic        m_axis_tuser_o    // out_of_range
);

  localparam int unsigned StA    = 0;
  localparam int unsigned StB    = 1;
  localparam int unsigned StC    = 2;
  localparam int unsigned StD    = 3;
  localparam int unsigned StSq0  = 4;
  localparam int unsigned SqSteps = 32;
  localparam int unsigned StE    = StSq0 + SqSteps;
  localparam int unsigned QBits  = 17;
  localparam int unsigned StDv0  = StE + 1;
  localparam int unsigned StOut  = StDv0 + QBits;
  localparam int unsigned NumSt  = StOut + 1;
  localparam logic [16:0] PosOne = 17'd16384;

  logic [6:0]       detail_q;
  logic [NumSt-1:0] vld_q;
  logic [NumSt-1:0] vld_in;
  logic [NumSt-1:0] en;

  // Configuration and effective level.
  logic [6:0] lvl;
  logic [8:0] lvl2, lvl3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detail_q <= 7'd1;
    end else if (cfg_we_i) begin
      detail_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (detail_q == 7'd0) begin
      lvl = 7'd1;
    end else if (detail_q > 7'(MaxDetail)) begin
      lvl = 7'(MaxDetail);
    end else begin
      lvl = detail_q;
    end
  end

  assign lvl2 = {1'b0, lvl, 1'b0};
  assign lvl3 = lvl2 + {2'b0, lvl};

  // Pipeline control.
  for (genvar k = 0; k < NumSt; k++) begin : g_en
    assign en[k] = m_axis_tready_i || !(&vld_q[NumSt-1:k]);
  end

  assign vld_in = {vld_q[NumSt-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumSt; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign s_axis_tready_o = en[StA];
  assign m_axis_tvalid_o = vld_q[StOut];

  // Stage A: range check, strip wrap, triangle case and weights.
  logic [2:0]  in_strip;
  logic [6:0]  in_col;
  logic [7:0]  in_row;
  logic [2:0]  s_a, nx_a, s_w, nx_w;
  logic [6:0]  col_w;
  logic        wrap, oor_a;
  logic [9:0]  t_a;
  logic signed [9:0] r_s, c_s, d_s, c1, c2;
  corner_e     id0, id1, id2;

  logic              a_oor_q;
  logic [7:0]        a_row_q;
  logic [9:0]        a_t_q;
  logic [2:0][9:0]   a_wt_q;
  corner_e           a_id_q [3];

  assign in_strip = s_axis_tdata_i[2:0];
  assign in_col   = s_axis_tdata_i[9:3];
  assign in_row   = s_axis_tdata_i[17:10];

  always_comb begin
    oor_a = ({2'b0, in_col} > {2'b0, lvl}) || ({1'b0, in_row} > lvl3);
    s_a   = mod5_f(in_strip);
    nx_a  = (s_a == 3'(NumStrips - 1)) ? 3'd0 : s_a + 3'd1;
    t_a   = 10'({3'b0, in_col}) + 10'(lvl) * 10'(s_a);
    wrap  = ({1'b0, in_row} >= lvl2) && (in_col == 7'd0);
    if (wrap) begin
      s_w   = (s_a == 3'd0) ? 3'(NumStrips - 1) : s_a - 3'd1;
      nx_w  = s_a;
      col_w = lvl;
    end else begin
      s_w   = s_a;
      nx_w  = nx_a;
      col_w = in_col;
    end
    r_s = $signed({2'b0, in_row});
    c_s = $signed({3'b0, col_w});
    d_s = $signed({3'b0, lvl});
    priority if (r_s <= d_s) begin
      id0 = corner_e'(CN0 + {1'b0, s_w});
      id1 = CNP;
      id2 = corner_e'(CN0 + {1'b0, nx_w});
      c1  = d_s - r_s;
      c2  = c_s;
    end else if (r_s >= (d_s <<< 1)) begin
      id0 = corner_e'(CS0 + {1'b0, nx_w});
      id1 = CSP;
      id2 = corner_e'(CS0 + {1'b0, s_w});
      c1  = r_s - (d_s <<< 1);
      c2  = d_s - c_s;
    end else if (r_s <= d_s + c_s) begin
      id0 = corner_e'(CN0 + {1'b0, nx_w});
      id1 = corner_e'(CS0 + {1'b0, nx_w});
      id2 = corner_e'(CN0 + {1'b0, s_w});
      c1  = r_s - d_s;
      c2  = d_s - c_s;
    end else begin
      id0 = corner_e'(CS0 + {1'b0, s_w});
      id1 = corner_e'(CS0 + {1'b0, nx_w});
      id2 = corner_e'(CN0 + {1'b0, s_w});
      c1  = c_s;
      c2  = (d_s <<< 1) - r_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StA]) begin
      a_oor_q   <= oor_a;
      a_row_q   <= in_row;
      a_t_q     <= t_a;
      a_wt_q[0] <= d_s - c1 - c2;
      a_wt_q[1] <= c1;
      a_wt_q[2] <= c2;
      a_id_q[0] <= id0;
      a_id_q[1] <= id1;
      a_id_q[2] <= id2;
    end
  end

  // Stage B: weighted sum of the three corners, buffer index.
  cvec_t cv [3];
  side_t b_d, b_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cv[j] = corner_f(a_id_q[j]);
    end
    b_d.oor   = a_oor_q;
    b_d.index = 16'(19'({a_row_q}) + 19'({lvl3} + 9'd1) * 19'(a_t_q));
    for (int c = 0; c < 3; c++) begin
      b_d.w[c] = 24'(24'($signed(a_wt_q[0])) * 24'($signed(cv[0][c]))
               + 24'($signed(a_wt_q[1])) * 24'($signed(cv[1][c]))
               + 24'($signed(a_wt_q[2])) * 24'($signed(cv[2][c])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StB]) begin
      b_q <= b_d;
    end
  end

  // Stage C: squares.
  side_t            c_side_q;
  logic [2:0][43:0] c_sq_q;

  always_ff @(posedge clk_i) begin
    if (en[StC]) begin
      c_side_q <= b_q;
      for (int c = 0; c < 3; c++) begin
        c_sq_q[c] <= 44'(48'($signed(b_q.w[c])) * 48'($signed(b_q.w[c])));
      end
    end
  end

  // Stage D: squared length, scaled for the root.
  side_t       d_side_q;
  logic [63:0] d_x_q;

  always_ff @(posedge clk_i) begin
    if (en[StD]) begin
      d_side_q <= c_side_q;
      d_x_q    <= {c_sq_q[0] + c_sq_q[1] + c_sq_q[2], 20'd0};
    end
  end

  // Square root, one result bit per stage.
  side_t       sq_side_q [SqSteps];
  logic [63:0] sq_x_q    [SqSteps];
  logic [63:0] sq_r_q    [SqSteps];

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] x_in, r_in, trial, x_nx, r_nx;
    side_t       side_in;

    if (k == 0) begin : g_first
      assign x_in    = d_x_q;
      assign r_in    = '0;
      assign side_in = d_side_q;
    end else begin : g_next
      assign x_in    = sq_x_q[k-1];
      assign r_in    = sq_r_q[k-1];
      assign side_in = sq_side_q[k-1];
    end

    assign trial = r_in + Bit;

    always_comb begin
      if (x_in >= trial) begin
        x_nx = x_in - trial;
        r_nx = (r_in >> 1) + Bit;
      end else begin
        x_nx = x_in;
        r_nx = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[StSq0 + k]) begin
        sq_x_q[k]    <= x_nx;
        sq_r_q[k]    <= r_nx;
        sq_side_q[k] <= side_in;
      end
    end
  end

  // Stage E: dividend and divisor for rounding division by 2L.
  logic [31:0] len;
  dstage_t     e_d, e_q;
  logic signed [23:0] we;
  logic [23:0] mag;

  assign len = sq_r_q[SqSteps-1][31:0];

  always_comb begin
    e_d.oor   = sq_side_q[SqSteps-1].oor;
    e_d.index = sq_side_q[SqSteps-1].index;
    e_d.lzero = (len == 32'd0);
    e_d.dv    = {len, 1'b0};
    we        = '0;
    mag       = '0;
    for (int c = 0; c < 3; c++) begin
      we          = $signed(sq_side_q[SqSteps-1].w[c]);
      mag         = (we < 0) ? 24'(-we) : 24'(we);
      e_d.neg[c]  = (we < 0);
      e_d.rem[c]  = (50'(mag) << 25) + 50'(len);
      e_d.q[c]    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StE]) begin
      e_q <= e_d;
    end
  end

  // Restoring division, one quotient bit per stage, three lanes.
  dstage_t dv_q [QBits];

  for (genvar j = 0; j < QBits; j++) begin : g_div
    localparam int unsigned QIdx = QBits - 1 - j;
    dstage_t     st_in, st_nx;
    logic [49:0] dsh;

    if (j == 0) begin : g_first
      assign st_in = e_q;
    end else begin : g_next
      assign st_in = dv_q[j-1];
    end

    assign dsh = 50'(st_in.dv) << QIdx;

    always_comb begin
      st_nx = st_in;
      for (int c = 0; c < 3; c++) begin
        if (st_in.rem[c] >= dsh) begin
          st_nx.rem[c]     = st_in.rem[c] - dsh;
          st_nx.q[c][QIdx] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[StDv0 + j]) begin
        dv_q[j] <= st_nx;
      end
    end
  end

  // Output stage: clamp, sign, out-of-range zeroing.
  dstage_t          fin;
  logic [16:0]      mq;
  logic [2:0][15:0] pos_d;
  logic [2:0][15:0] pos_q;
  logic [15:0]      idx_d, idx_q;
  logic             oor_q;

  assign fin = dv_q[QBits-1];

  always_comb begin
    mq    = '0;
    idx_d = fin.oor ? 16'd0 : fin.index;
    for (int c = 0; c < 3; c++) begin
      mq = fin.lzero ? 17'd0 : fin.q[c];
      if (mq > PosOne) begin
        mq = PosOne;
      end
      if (fin.oor) begin
        pos_d[c] = '0;
      end else if (fin.neg[c]) begin
        pos_d[c] = 16'd0 - mq[15:0];
      end else begin
        pos_d[c] = mq[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StOut]) begin
      pos_q <= pos_d;
      idx_q <= idx_d;
      oor_q <= fin.oor;
    end
  end

  assign m_axis_tdata_o = {pos_q[2], pos_q[1], pos_q[0], idx_q};
  assign m_axis_tuser_o = oor_q;

  // Checks.
  `ICOVG_ASSERT_IMPL(a_oor_zero, m_axis_tvalid_o && m_axis_tuser_o,
                     m_axis_tdata_o == 64'd0, "out-of-range word carries nonzero data")
  `ICOVG_ASSERT_IMPL(a_pos_range, m_axis_tvalid_o,
                     ($signed(pos_q[0]) <= 16'sd16384) && ($signed(pos_q[0]) >= -16'sd16384) && ($signed(pos_q[1]) <= 16'sd16384) && ($signed(pos_q[1]) >= -16'sd16384) && ($signed(pos_q[2]) <= 16'sd16384) && ($signed(pos_q[2]) >= -16'sd16384),
                     "vertex coordinate outside unit range")
  `ICOVG_ASSERT_IMPL(a_ready_when_out_empty, !m_axis_tvalid_o,
                     s_axis_tready_o, "input stalled while output stage is empty")
  `ICOVG_ASSERT_NEXT(a_stage_a_holds, vld_q[StA] && !en[StA],
                     vld_q[StA], "stalled word lost in first stage")

endmodule
